>>> hdl/ssuid_pkg.sv
// Package for the small set union/intersection/difference block.
// Holds field widths, request and status codes, and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package ssuid_pkg;

    localparam int unsigned NUM_SETS_DEF     = 8;
    localparam int unsigned SET_CAPACITY_DEF = 16;

    localparam int unsigned VAL_W       = 32;
    localparam int unsigned REQ_W       = 2;
    localparam int unsigned SET_FIELD_W = 3;
    localparam int unsigned STATUS_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_UNION = 2'd1,
        REQ_INTER = 2'd2,
        REQ_DIFF  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DUP  = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    // Request transaction payload as seen by the datapath
    typedef struct packed {
        t_req                    req_type;
        logic [SET_FIELD_W-1:0]  set_a;
        logic [SET_FIELD_W-1:0]  set_b;
        logic signed [VAL_W-1:0] value;
    } t_req_item;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic load;
        logic add;
        logic scan;
        logic fin;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_add;
        logic ld_done;
        logic scan_done;
        logic push_ok;
    } t_stat;

endpackage

>>> hdl/ssuid_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on ssuid_pkg for field widths.
`timescale 1ns / 1ps

interface ssuid_req_if import ssuid_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic [SET_FIELD_W-1:0]  set_a;
    logic [SET_FIELD_W-1:0]  set_b;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output req_type, output set_a, output set_b,
                    output value, input ready);
    modport sink   (input valid, input req_type, input set_a, input set_b,
                    input value, output ready);
endinterface

interface ssuid_res_if import ssuid_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] element;
    logic                    is_last;
    logic                    is_empty;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, output element, output is_last, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input element, input is_last, input is_empty,
                    input status, output ready);
endinterface

>>> hdl/ssuid_datapath.sv
// Datapath: member store, count memory, set buffers, membership compare and output register.
// Depends on ssuid_pkg and ssuid_res_if; driven by ssuid_ctrl through t_cmd.
`timescale 1ns / 1ps

module ssuid_datapath import ssuid_pkg::*; #(
    parameter int unsigned NUM_SETS     = NUM_SETS_DEF,
    parameter int unsigned SET_CAPACITY = SET_CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_req_item          i_item,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    ssuid_res_if.source        o_res
);

    localparam int unsigned SET_W  = $clog2(NUM_SETS);
    localparam int unsigned CNT_W  = $clog2(SET_CAPACITY + 1);
    localparam int unsigned BIX_W  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int unsigned DEPTH  = NUM_SETS * SET_CAPACITY;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    // request latch
    t_req                    r_req;
    logic [SET_W-1:0]        r_ia, r_ib;
    logic signed [VAL_W-1:0] r_value;
    logic [SET_W-1:0]        idx_a_in, idx_b_in, cnt_addr_a, cnt_addr_b;

    // count memory with per-set valid bits
    logic [CNT_W-1:0]        r_cnt_mem [NUM_SETS];
    logic [NUM_SETS-1:0]     r_cnt_vld;
    logic [CNT_W-1:0]        r_cnt_rd_a, r_cnt_rd_b;
    logic                    r_cnt_va, r_cnt_vb;
    logic [CNT_W-1:0]        na, nb, lmax;

    // member store
    logic signed [VAL_W-1:0] r_store [DEPTH];
    logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b, wr_addr;
    logic signed [VAL_W-1:0] r_rd_a, r_rd_b;

    // buffer load
    logic [CNT_W-1:0]        r_li;
    logic                    r_ld_vld;
    logic [BIX_W-1:0]        r_ld_idx;
    logic                    ld_go;
    logic signed [VAL_W-1:0] r_buf_a [SET_CAPACITY];
    logic signed [VAL_W-1:0] r_buf_b [SET_CAPACITY];

    // scan and compare
    logic [CNT_W-1:0]        r_si;
    logic                    r_phase;
    logic signed [VAL_W-1:0] elem, cmp_key, lane_val;
    logic                    use_a, hit, take, need_push, scan_adv, scan_act;
    logic                    scan_more, scan_done, phase_switch;
    logic [CNT_W-1:0]        cmp_cnt, scan_lim;

    // pending item and output register
    logic                    r_pend_vld;
    logic signed [VAL_W-1:0] r_pend;
    logic                    r_out_vld, r_out_last, r_out_empty;
    logic signed [VAL_W-1:0] r_out_elem;
    t_status                 r_out_status, add_status;
    logic                    push_ok, push, add_fire, add_wr, fin_fire;

    // reduce 3-bit set fields modulo the set count
    always_comb begin
        idx_a_in = '0;
        idx_b_in = '0;
        for (int r = 0; r < (1 << SET_FIELD_W); r++) begin
            if (i_item.set_a == SET_FIELD_W'(r)) idx_a_in = SET_W'(r % NUM_SETS);
            if (i_item.set_b == SET_FIELD_W'(r)) idx_b_in = SET_W'(r % NUM_SETS);
        end
    end

    assign cnt_addr_a = i_cmd.start ? idx_a_in : r_ia;
    assign cnt_addr_b = i_cmd.start ? idx_b_in : r_ib;

    assign na   = r_cnt_va ? r_cnt_rd_a : '0;
    assign nb   = r_cnt_vb ? r_cnt_rd_b : '0;
    assign lmax = (na > nb) ? na : nb;

    assign ld_go     = i_cmd.load && (r_li < lmax);
    assign rd_addr_a = ADDR_W'(r_ia) * ADDR_W'(SET_CAPACITY) + ADDR_W'(r_li);
    assign rd_addr_b = ADDR_W'(r_ib) * ADDR_W'(SET_CAPACITY) + ADDR_W'(r_li);
    assign wr_addr   = ADDR_W'(r_ia) * ADDR_W'(SET_CAPACITY) + ADDR_W'(na);

    // phase 0 walks A against B, phase 1 (union only) walks B against A
    assign elem     = r_phase ? r_buf_b[r_si[BIX_W-1:0]] : r_buf_a[r_si[BIX_W-1:0]];
    assign use_a    = (r_req == REQ_ADD) || r_phase;
    assign cmp_key  = (r_req == REQ_ADD) ? r_value : elem;
    assign cmp_cnt  = use_a ? na : nb;
    assign scan_lim = r_phase ? nb : na;

    always_comb begin
        hit      = 1'b0;
        lane_val = '0;
        for (int j = 0; j < SET_CAPACITY; j++) begin
            lane_val = use_a ? r_buf_a[j] : r_buf_b[j];
            if ((CNT_W'(j) < cmp_cnt) && (lane_val == cmp_key)) hit = 1'b1;
        end
    end

    always_comb begin
        case (r_req)
            REQ_UNION: take = r_phase ? !hit : 1'b1;
            REQ_INTER: take = hit;
            REQ_DIFF:  take = !hit;
            default:   take = 1'b0;
        endcase
    end

    assign scan_more    = r_si < scan_lim;
    assign scan_act     = i_cmd.scan && scan_more;
    assign need_push    = scan_act && take && r_pend_vld;
    assign scan_adv     = scan_act && (!need_push || push_ok);
    assign scan_done    = !scan_more && (r_phase || (r_req != REQ_UNION));
    assign phase_switch = i_cmd.scan && !scan_more && !r_phase && (r_req == REQ_UNION);

    assign add_status = hit ? STATUS_DUP :
                        (na == CNT_W'(SET_CAPACITY)) ? STATUS_FULL : STATUS_OK;

    assign push_ok  = !r_out_vld || o_res.ready;
    assign add_fire = i_cmd.add && push_ok;
    assign add_wr   = add_fire && (add_status == STATUS_OK);
    assign fin_fire = i_cmd.fin && push_ok;
    assign push     = add_fire || fin_fire || (scan_adv && need_push);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld  <= '0;
            r_li       <= '0;
            r_ld_vld   <= 1'b0;
            r_si       <= '0;
            r_phase    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_ld_vld <= ld_go;
            if (add_wr) r_cnt_vld[r_ia] <= 1'b1;
            if (i_cmd.start) begin
                r_li       <= '0;
                r_si       <= '0;
                r_phase    <= 1'b0;
                r_pend_vld <= 1'b0;
            end else begin
                if (ld_go) r_li <= r_li + CNT_W'(1);
                if (scan_adv) begin
                    r_si <= r_si + CNT_W'(1);
                    if (take) r_pend_vld <= 1'b1;
                end
                if (phase_switch) begin
                    r_phase <= 1'b1;
                    r_si    <= '0;
                end
                if (fin_fire) r_pend_vld <= 1'b0;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req   <= i_item.req_type;
            r_ia    <= idx_a_in;
            r_ib    <= idx_b_in;
            r_value <= i_item.value;
        end
        r_ld_idx <= r_li[BIX_W-1:0];
        if (r_ld_vld) begin
            r_buf_a[r_ld_idx] <= r_rd_a;
            r_buf_b[r_ld_idx] <= r_rd_b;
        end
        if (scan_adv && take) r_pend <= elem;
        if (push) begin
            if (add_fire) begin
                r_out_elem   <= r_value;
                r_out_last   <= 1'b1;
                r_out_empty  <= 1'b0;
                r_out_status <= add_status;
            end else if (fin_fire) begin
                r_out_elem   <= r_pend_vld ? r_pend : '0;
                r_out_last   <= 1'b1;
                r_out_empty  <= !r_pend_vld;
                r_out_status <= STATUS_OK;
            end else begin
                r_out_elem   <= r_pend;
                r_out_last   <= 1'b0;
                r_out_empty  <= 1'b0;
                r_out_status <= STATUS_OK;
            end
        end
    end

    // count memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (add_wr) r_cnt_mem[r_ia] <= na + CNT_W'(1);
        r_cnt_rd_a <= r_cnt_mem[cnt_addr_a];
        r_cnt_rd_b <= r_cnt_mem[cnt_addr_b];
        r_cnt_va   <= r_cnt_vld[cnt_addr_a];
        r_cnt_vb   <= r_cnt_vld[cnt_addr_b];
    end

    // member store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (add_wr) r_store[wr_addr] <= r_value;
        r_rd_a <= r_store[rd_addr_a];
        r_rd_b <= r_store[rd_addr_b];
    end

    assign o_stat.is_add    = (r_req == REQ_ADD);
    assign o_stat.ld_done   = !(r_li < lmax) && !r_ld_vld;
    assign o_stat.scan_done = scan_done;
    assign o_stat.push_ok   = push_ok;

    assign o_res.valid    = r_out_vld;
    assign o_res.element  = r_out_elem;
    assign o_res.is_last  = r_out_last;
    assign o_res.is_empty = r_out_empty;
    assign o_res.status   = r_out_status;

endmodule

>>> hdl/ssuid_ctrl.sv
// Controller state machine: sequences accept, buffer load, add or scan, and final item.
// Depends on ssuid_pkg for t_cmd and t_stat.
`timescale 1ns / 1ps

module ssuid_ctrl import ssuid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_ADD  = 5'b00100,
        S_SCAN = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.start = i_in_valid;
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_stat.ld_done) n_state = i_stat.is_add ? S_ADD : S_SCAN;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (i_stat.push_ok) n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_stat.push_ok) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/small_set_union_intersect_diff_core.sv
// Top level of the small set store with union, intersection and difference.
// Depends on ssuid_pkg, ssuid_if, ssuid_ctrl and ssuid_datapath.
//
// Usage:
//   i_req carries one request transaction: add value to set_a, or union,
//   intersection or difference (set_a minus set_b). Set fields at or beyond
//   NUM_SETS are reduced modulo NUM_SETS.
//   o_res carries result transactions. An add gives one item echoing the value
//   with a status (ok, already present, set full). A set operation streams the
//   answer members in order, is_last on the final one; an empty answer gives a
//   single item with is_empty and is_last set.
// Timing: one request is processed at a time. The bound is the element walk
//   (A, then B for a union): one element per cycle while no taken member waits
//   on a held result, each compared in parallel against the buffered members
//   of the other set. An add result is registered once the buffer load is done
//   and the result register can take it; a set operation holds each taken
//   member until the next one is found, so its first result comes two taken
//   members into the walk at the earliest, or at the end of the walk when
//   only one member is taken.
// Reset: clears all member counts at once; member storage is not cleared and
//   needs no sweep. A held result blocks further pushes when o_res stalls;
//   i_req becomes ready again once the final item of the request is registered.
`timescale 1ns / 1ps

module small_set_union_intersect_diff_core import ssuid_pkg::*; #(
    parameter int unsigned NUM_SETS     = NUM_SETS_DEF,
    parameter int unsigned SET_CAPACITY = SET_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssuid_req_if.sink   i_req,
    ssuid_res_if.source o_res
);

    t_req_item w_item;
    t_cmd      w_cmd;
    t_stat     w_stat;
    logic      w_ready;

    // pack the request transaction for the datapath
    assign w_item.req_type = t_req'(i_req.req_type);
    assign w_item.set_a    = i_req.set_a;
    assign w_item.set_b    = i_req.set_b;
    assign w_item.value    = i_req.value;

    assign i_req.ready = w_ready;

    ssuid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ssuid_datapath #(
        .NUM_SETS     (NUM_SETS),
        .SET_CAPACITY (SET_CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_res   (o_res)
    );

    // one request in flight: ready drops right after an accept
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    // an empty answer is always the last item of its request
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_empty) |-> o_res.is_last)
        else $error("empty result not marked last");

    // non-ok status only on the single, non-empty item of an add
    a_status_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != STATUS_OK)) |-> (o_res.is_last && !o_res.is_empty))
        else $error("add status on an unexpected result");

    // controller issues at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.start, w_cmd.load, w_cmd.add, w_cmd.scan, w_cmd.fin}))
        else $error("conflicting datapath commands");

endmodule

>>> sim/tb_small_set_union_intersect_diff_core.sv
// Self-checking testbench for small_set_union_intersect_diff_core.
// Runs directed and random add/union/intersection/difference requests and checks results.
// Depends on ssuid_pkg, ssuid_if and the core RTL.
`timescale 1ns / 1ps

module tb_small_set_union_intersect_diff_core;
    import ssuid_pkg::*;

    localparam int unsigned NSETS        = NUM_SETS_DEF;
    localparam int unsigned CAP          = SET_CAPACITY_DEF;
    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam int unsigned IDLE_PCT     = 16;
    // Item window with no idling on either side
    localparam int unsigned CALM_FIRST   = 60;
    localparam int unsigned CALM_LAST    = 140;
    // Long receiver hold-off, started once the sender has moved this many items
    localparam int unsigned HOLD_AT_ITEM = 180;
    localparam int unsigned HOLD_CYCLES  = 400;
    // Random item index at which the sender waits for every answer to drain
    localparam int unsigned PAUSE_AT     = 240;
    // Full union of two full sets plus margin
    localparam int unsigned TAIL_CYCLES  = 2 * (3 * CAP + 6);
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // One result transaction as the core should present it
    typedef struct packed {
        logic signed [VAL_W-1:0] element;
        logic                    is_last;
        logic                    is_empty;
        t_status                 status;
    } t_set_result;

    // Shadow copy of the set store plus the queue of answers still owed by the core
    class set_algebra_scoreboard;
        localparam int unsigned REPORT_CAP = 40;

        logic [VAL_W-1:0] members [NSETS][CAP];
        int unsigned      member_cnt [NSETS];
        t_set_result      answer_q [$];
        int unsigned      fail_cnt;

        function new();
            foreach (member_cnt[s]) member_cnt[s] = 0;
            fail_cnt = 0;
        endfunction

        function int unsigned pending();
            return answer_q.size();
        endfunction

        function bit holds(int unsigned set_idx, logic [VAL_W-1:0] val);
            for (int unsigned i = 0; i < member_cnt[set_idx]; i++) begin
                if (members[set_idx][i] == val) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_answer(logic [VAL_W-1:0] val, logic last, logic empty,
                                  t_status st);
            t_set_result r;
            r.element  = val;
            r.is_last  = last;
            r.is_empty = empty;
            r.status   = st;
            answer_q.push_back(r);
        endfunction

        // Update the shadow store and queue the answers for one accepted request
        function void note_request(t_req kind, logic [SET_FIELD_W-1:0] sa_raw,
                                   logic [SET_FIELD_W-1:0] sb_raw, logic [VAL_W-1:0] val);
            int unsigned      sa;
            int unsigned      sb;
            int unsigned      na;
            int unsigned      nb;
            int unsigned      taken;
            logic [VAL_W-1:0] m;
            bit               in_b;
            sa = int'(sa_raw) % NSETS;
            sb = int'(sb_raw) % NSETS;
            na = member_cnt[sa];
            nb = member_cnt[sb];
            if (kind == REQ_ADD) begin
                // A duplicate wins over a full set
                if (holds(sa, val)) begin
                    push_answer(val, 1'b1, 1'b0, STATUS_DUP);
                end else if (na >= CAP) begin
                    push_answer(val, 1'b1, 1'b0, STATUS_FULL);
                end else begin
                    members[sa][na] = val;
                    member_cnt[sa]  = na + 1;
                    push_answer(val, 1'b1, 1'b0, STATUS_OK);
                end
                return;
            end
            taken = 0;
            for (int unsigned i = 0; i < na; i++) begin
                m    = members[sa][i];
                in_b = holds(sb, m);
                if (kind == REQ_UNION || (kind == REQ_INTER && in_b) ||
                    (kind == REQ_DIFF && !in_b)) begin
                    push_answer(m, 1'b0, 1'b0, STATUS_OK);
                    taken++;
                end
            end
            if (kind == REQ_UNION) begin
                for (int unsigned i = 0; i < nb; i++) begin
                    m = members[sb][i];
                    if (!holds(sa, m)) begin
                        push_answer(m, 1'b0, 1'b0, STATUS_OK);
                        taken++;
                    end
                end
            end
            if (taken == 0)
                push_answer('0, 1'b1, 1'b1, STATUS_OK);
            else
                answer_q[answer_q.size()-1].is_last = 1'b1;
        endfunction

        task report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
            fail_cnt++;
            if (fail_cnt <= REPORT_CAP)
                $display("[%0t] mismatch %0d on %s: got %h, want %h",
                         $time, fail_cnt, what, got, want);
        endtask

        // Compare one accepted result against the oldest owed answer
        task check_result(logic [VAL_W-1:0] elem, logic last, logic empty,
                          logic [STATUS_W-1:0] st);
            t_set_result want;
            if (answer_q.size() == 0) begin
                report_mismatch("result with nothing owed", elem, '0);
                return;
            end
            want = answer_q.pop_front();
            // An empty answer carries element zero
            if (elem !== want.element)
                report_mismatch("element", elem, want.element);
            if (last !== want.is_last)
                report_mismatch("is_last", VAL_W'(last), VAL_W'(want.is_last));
            if (empty !== want.is_empty)
                report_mismatch("is_empty", VAL_W'(empty), VAL_W'(want.is_empty));
            if (st !== want.status)
                report_mismatch("status", VAL_W'(st), VAL_W'(want.status));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned sent_cnt  = 0;
    int unsigned cycle_cnt = 0;

    set_algebra_scoreboard set_sb = new();

    ssuid_req_if req_if ();
    ssuid_res_if res_if ();

    small_set_union_intersect_diff_core #(
        .NUM_SETS     (NSETS),
        .SET_CAPACITY (CAP)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** small_set_union_intersect_diff_core: FAILED **");
            $finish;
        end
    end

    // Check every result transaction against the oldest owed answer
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            set_sb.check_result(res_if.element, res_if.is_last, res_if.is_empty,
                                res_if.status);
    end

    // Result side: random stalls, a calm window, and one long hold-off that
    // backs the core up until it stops taking requests
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_cnt >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic bit in_calm_window();
        return sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST;
    endfunction

    // Offer one request, idling first at random, and hold it until accepted
    task automatic offer_request(input t_req kind, input logic [SET_FIELD_W-1:0] sa,
                                 input logic [SET_FIELD_W-1:0] sb,
                                 input logic [VAL_W-1:0] val);
        int unsigned gap;
        gap = 0;
        if (!in_calm_window() && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(6, 1);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.set_a    <= sa;
        req_if.set_b    <= sb;
        req_if.value    <= val;
        do @(posedge i_clk); while (!req_if.ready);
        set_sb.note_request(kind, sa, sb, val);
        sent_cnt <= sent_cnt + 1;
    endtask

    task automatic wait_for_answers();
        while (set_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly a small value pool so duplicates and overlaps are common
    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50) return VAL_W'($urandom_range(47)) - VAL_W'(24);
        if (roll < 60) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return VAL_W'($urandom);
    endfunction

    // Adds lean on sets 0..3 so they fill up; sets 4..7 stay small for longer
    task automatic offer_random_request();
        t_req                   kind;
        logic [SET_FIELD_W-1:0] sa;
        logic [SET_FIELD_W-1:0] sb;
        if ($urandom_range(99) < 55) begin
            kind = REQ_ADD;
            sa   = ($urandom_range(99) < 85) ? SET_FIELD_W'($urandom_range(3))
                                              : SET_FIELD_W'($urandom_range(7, 4));
        end else begin
            kind = t_req'($urandom_range(REQ_DIFF, REQ_UNION));
            sa   = SET_FIELD_W'($urandom_range(7));
        end
        sb = SET_FIELD_W'($urandom_range(7));
        offer_request(kind, sa, sb, pick_value());
    endtask

    task automatic run_directed();
        // Empty answer from two never-written sets
        offer_request(REQ_UNION, 3'd0, 3'd1, 32'h0);
        // Extremes into set 0, then a duplicate
        offer_request(REQ_ADD, 3'd0, 3'd0, 32'h8000_0000);
        offer_request(REQ_ADD, 3'd0, 3'd7, 32'h7FFF_FFFF);
        offer_request(REQ_ADD, 3'd0, 3'd0, 32'h0000_0000);
        offer_request(REQ_ADD, 3'd0, 3'd0, 32'hFFFF_FFFF);
        offer_request(REQ_ADD, 3'd0, 3'd0, 32'h0000_0000);
        // Partly overlapping set 7
        offer_request(REQ_ADD, 3'd7, 3'd7, 32'hFFFF_FFFF);
        offer_request(REQ_ADD, 3'd7, 3'd0, 32'h1234_5678);
        offer_request(REQ_UNION, 3'd0, 3'd7, 32'hFFFF_FFFF);
        offer_request(REQ_INTER, 3'd0, 3'd7, 32'h0);
        offer_request(REQ_DIFF, 3'd0, 3'd7, 32'h0);
        // Same set on both sides
        offer_request(REQ_UNION, 3'd0, 3'd0, 32'h0);
        offer_request(REQ_DIFF, 3'd7, 3'd7, 32'h0);
        // One side empty
        offer_request(REQ_INTER, 3'd0, 3'd5, 32'h0);
        offer_request(REQ_UNION, 3'd5, 3'd0, 32'h0);
        // Fill set 0, overflow it, then repeat a member of the full set
        for (int i = 0; i < CAP - 4; i++)
            offer_request(REQ_ADD, 3'd0, 3'd0, 32'd1000 + i);
        offer_request(REQ_ADD, 3'd0, 3'd0, 32'd2000);
        offer_request(REQ_ADD, 3'd0, 3'd0, 32'h7FFF_FFFF);
    endtask

    initial begin
        int unsigned waited;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_ADD;
        req_if.set_a    <= '0;
        req_if.set_b    <= '0;
        req_if.value    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == PAUSE_AT) begin
                // Drop valid and let every owed answer come back first
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                wait_for_answers();
            end
            offer_random_request();
        end
        req_if.valid <= 1'b0;
        @(posedge i_clk);

        waited = 0;
        while (set_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (set_sb.pending() != 0)
            set_sb.report_mismatch("answers never delivered", VAL_W'(set_sb.pending()), '0);
        // Catch any stray result after the last owed one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (set_sb.fail_cnt == 0) begin
            $display("** small_set_union_intersect_diff_core: PASSED **");
        end else begin
            $display("** small_set_union_intersect_diff_core: FAILED **");
        end
        $finish;
    end

endmodule
